>>> hw/rtl/dpw_pkg.sv
// ----------------------------------------------------------------------------
// dpw_pkg
// Types and constants shared by the dosage/probability word encoder.
// ----------------------------------------------------------------------------
package dpw_pkg;

  // fixed point format of the incoming values
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned DOSE_W    = 26;
  localparam int unsigned PROB_W    = 25;
  localparam int unsigned SUM_W     = 27;
  localparam int unsigned TOL_W     = 16;
  localparam int unsigned WORD_W    = 16;

  localparam logic [SUM_W-1:0]  ONE_FIX      = SUM_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] WORD_MISSING = 16'hFFFF;
  localparam logic [WORD_W-1:0] WORD_FLAG    = 16'h8000;
  localparam logic [WORD_W-1:0] WORD_SAT     = 16'hFFFE;

  // extra word counts
  localparam logic [1:0] CNT_NONE  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_THREE = 2'd3;

  // configuration register indexes
  localparam logic REG_INCLUDE_PROB = 1'b0;
  localparam logic REG_TOLERANCE    = 1'b1;

  typedef struct packed {
    logic              dosage_missing;
    logic [DOSE_W-1:0] dosage_value;
    logic              hom_ref_missing;
    logic [PROB_W-1:0] hom_ref_prob;
    logic              het_missing;
    logic [PROB_W-1:0] het_prob;
    logic              hom_alt_missing;
    logic [PROB_W-1:0] hom_alt_prob;
  } dpw_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] dosage_word;
    logic [1:0]        extra_count;
    logic [WORD_W-1:0] extra_word_first;
    logic [WORD_W-1:0] extra_word_second;
    logic [WORD_W-1:0] extra_word_third;
  } dpw_out_t;

  // stage advance strobes handed to the datapath units
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } dpw_adv_t;

endpackage

>>> hw/rtl/dosage_probability_word_encoder.sv
// ----------------------------------------------------------------------------
// dosage_probability_word_encoder
// Quantizes a dosage and three genotype probabilities into 16-bit words.
// ----------------------------------------------------------------------------
// Three-stage pipeline taking one item per clock and giving one result per
// item; that rate holds while the output is not stalled. Stage 1
// scales the four values by QUANT_SCALE and forms the probability sums,
// stage 2 rounds, saturates and compares against the tolerance, stage 3
// encodes into the output register. A stall at the output backs up through
// the stages; empty stages still fill, so up to three items are in flight.
// Configuration writes take effect at once and are meant for an idle block.
module dosage_probability_word_encoder #(
  parameter int unsigned QUANT_SCALE = 10000
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dpw_pkg::dpw_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dpw_pkg::dpw_out_t           out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [dpw_pkg::TOL_W-1:0]   cfg_wdata
);
  import dpw_pkg::*;

  logic             incl_prob_r;
  logic [TOL_W-1:0] tolerance_r;

  logic     s1_valid_r, s2_valid_r, out_valid_r;
  logic     s3_en;
  dpw_adv_t adv;

  // flags carried alongside the datapath
  logic s1_dmiss_r, s1_pmiss_r, s1_nz_r;
  logic s2_dmiss_r, s2_pmiss_r, s2_nz_r;

  logic [WORD_W-1:0] q_dose, q_p0, q_p1, q_p2;
  logic              consistent;

  dpw_out_t out_r, out_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incl_prob_r <= 1'b1;
      tolerance_r <= TOL_W'(17);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INCLUDE_PROB: incl_prob_r <= cfg_wdata[0];
        REG_TOLERANCE:    tolerance_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves when empty or when the next one moves
  assign s3_en     = !out_valid_r || out_ready;
  assign adv.s2_en = !s2_valid_r || s3_en;
  assign adv.s1_en = !s1_valid_r || adv.s2_en;
  assign in_ready  = adv.s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv.s1_en) s1_valid_r  <= in_valid;
      if (adv.s2_en) s2_valid_r  <= s1_valid_r;
      if (s3_en)     out_valid_r <= s2_valid_r;
    end
  end

  // flag pipeline
  always_ff @(posedge clk) begin
    if (adv.s1_en) begin
      s1_dmiss_r <= in_data.dosage_missing;
      s1_pmiss_r <= in_data.hom_ref_missing | in_data.het_missing | in_data.hom_alt_missing;
      s1_nz_r    <= (in_data.hom_ref_prob != '0) && (in_data.hom_alt_prob != '0);
    end
    if (adv.s2_en) begin
      s2_dmiss_r <= s1_dmiss_r;
      s2_pmiss_r <= s1_pmiss_r;
      s2_nz_r    <= s1_nz_r;
    end
  end

  // quantizers
  dpw_quant #(.IN_W(DOSE_W), .QUANT_SCALE(QUANT_SCALE)) u_q_dose (
    .clk(clk), .adv(adv), .in_val(in_data.dosage_value), .q_out(q_dose)
  );
  dpw_quant #(.IN_W(PROB_W), .QUANT_SCALE(QUANT_SCALE)) u_q_p0 (
    .clk(clk), .adv(adv), .in_val(in_data.hom_ref_prob), .q_out(q_p0)
  );
  dpw_quant #(.IN_W(PROB_W), .QUANT_SCALE(QUANT_SCALE)) u_q_p1 (
    .clk(clk), .adv(adv), .in_val(in_data.het_prob), .q_out(q_p1)
  );
  dpw_quant #(.IN_W(PROB_W), .QUANT_SCALE(QUANT_SCALE)) u_q_p2 (
    .clk(clk), .adv(adv), .in_val(in_data.hom_alt_prob), .q_out(q_p2)
  );

  // consistency check
  dpw_check u_check (
    .clk        (clk),
    .adv        (adv),
    .tolerance  (tolerance_r),
    .dose       (in_data.dosage_value),
    .p0         (in_data.hom_ref_prob),
    .p1         (in_data.het_prob),
    .p2         (in_data.hom_alt_prob),
    .consistent (consistent)
  );

  // stage 3: word encoding
  always_comb begin
    out_nxt = '0;
    if (s2_dmiss_r) begin
      out_nxt.dosage_word = WORD_MISSING;
    end else begin
      out_nxt.dosage_word = q_dose;
      if (incl_prob_r) begin
        if (s2_pmiss_r) begin
          out_nxt.dosage_word      = q_dose | WORD_FLAG;
          out_nxt.extra_count      = CNT_ONE;
          out_nxt.extra_word_first = WORD_MISSING;
        end else if (consistent) begin
          if (s2_nz_r) begin
            out_nxt.dosage_word      = q_dose | WORD_FLAG;
            out_nxt.extra_count      = CNT_ONE;
            out_nxt.extra_word_first = q_p1;
          end
        end else begin
          out_nxt.dosage_word       = q_dose | WORD_FLAG;
          out_nxt.extra_count       = CNT_THREE;
          out_nxt.extra_word_first  = q_p1 | WORD_FLAG;
          out_nxt.extra_word_second = q_p0;
          out_nxt.extra_word_third  = q_p2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/dpw_quant.sv
// ----------------------------------------------------------------------------
// dpw_quant
// Two-stage quantizer: multiply by the scale, then round half up and saturate.
// ----------------------------------------------------------------------------
module dpw_quant #(
  parameter int unsigned IN_W        = 25,
  parameter int unsigned QUANT_SCALE = 10000
) (
  input  logic                  clk,
  input  dpw_pkg::dpw_adv_t     adv,
  input  logic [IN_W-1:0]       in_val,
  output logic [dpw_pkg::WORD_W-1:0] q_out
);
  import dpw_pkg::*;

  localparam int unsigned SCALE_W = $clog2(QUANT_SCALE + 1);
  localparam int unsigned PROD_W  = IN_W + SCALE_W;
  localparam int unsigned RND_W   = PROD_W + 1;
  localparam int unsigned Q_W     = RND_W - FRAC_BITS;
  localparam int unsigned CMP_W   = (Q_W > WORD_W) ? Q_W : WORD_W;

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [RND_W-1:0]  rnd;
  logic [CMP_W-1:0]  q_ext;
  logic [WORD_W-1:0] q_r, q_nxt;

  // stage 1: scale
  assign prod_nxt = PROD_W'(in_val) * PROD_W'(QUANT_SCALE);

  // stage 2: round half up, drop fraction, keep clear of the missing code
  always_comb begin
    rnd   = RND_W'(prod_r) + (RND_W'(1) << (FRAC_BITS - 1));
    q_ext = CMP_W'(rnd[RND_W-1:FRAC_BITS]);
    q_nxt = (q_ext > CMP_W'(WORD_SAT)) ? WORD_SAT : q_ext[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv.s1_en) begin
      prod_r <= prod_nxt;
    end
    if (adv.s2_en) begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

>>> hw/rtl/dpw_check.sv
// ----------------------------------------------------------------------------
// dpw_check
// Two-stage consistency check of the probabilities against one and the dosage.
// ----------------------------------------------------------------------------
module dpw_check (
  input  logic                        clk,
  input  dpw_pkg::dpw_adv_t           adv,
  input  logic [dpw_pkg::TOL_W-1:0]   tolerance,
  input  logic [dpw_pkg::DOSE_W-1:0]  dose,
  input  logic [dpw_pkg::PROB_W-1:0]  p0,
  input  logic [dpw_pkg::PROB_W-1:0]  p1,
  input  logic [dpw_pkg::PROB_W-1:0]  p2,
  output logic                        consistent
);
  import dpw_pkg::*;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] exp_r, exp_nxt;
  logic [SUM_W-1:0] dose_r;
  logic [SUM_W-1:0] sum_diff, dose_diff;
  logic             ok_r, ok_nxt;

  // stage 1: p0+p1+p2 and the dosage implied by p1 + 2*p2
  always_comb begin
    sum_nxt = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
    exp_nxt = SUM_W'(p1) + (SUM_W'(p2) << 1);
  end

  // stage 2: absolute differences against the tolerance
  always_comb begin
    sum_diff  = (sum_r >= ONE_FIX) ? (sum_r - ONE_FIX) : (ONE_FIX - sum_r);
    dose_diff = (exp_r >= dose_r) ? (exp_r - dose_r) : (dose_r - exp_r);
    ok_nxt    = (sum_diff < SUM_W'(tolerance)) && (dose_diff < SUM_W'(tolerance));
  end

  always_ff @(posedge clk) begin
    if (adv.s1_en) begin
      sum_r  <= sum_nxt;
      exp_r  <= exp_nxt;
      dose_r <= SUM_W'(dose);
    end
    if (adv.s2_en) begin
      ok_r <= ok_nxt;
    end
  end

  assign consistent = ok_r;

endmodule

>>> hw/rtl/dpw_checker.sv
// ----------------------------------------------------------------------------
// dpw_checker
// Port-level checks on the result channel of the word encoder.
// ----------------------------------------------------------------------------
module dpw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input dpw_pkg::dpw_out_t  out_data
);
  import dpw_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // only 0, 1 or 3 extra words
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.extra_count != 2'd2))
    else $error("illegal extra word count");

  // extra words always flag the dosage word
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.extra_count != CNT_NONE) |-> out_data.dosage_word[15])
    else $error("extra words without flag bit");

  // missing dosage carries no extras; its first extra word is zero
  a_missing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.dosage_word == WORD_MISSING) |->
      (out_data.extra_count == CNT_NONE) && (out_data.extra_word_first == '0))
    else $error("missing dosage with extra words");

endmodule

bind dosage_probability_word_encoder dpw_checker u_dpw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
